// File: src/smd_pkg.sv
// shared types and constants for the softmax block
package smd_pkg;

  typedef struct packed {
    logic signed [15:0] score;
    logic               last_element;
  } smd_in_t;

  typedef struct packed {
    logic [15:0] probability;
    logic [14:0] derivative;
    logic        last_result;
  } smd_out_t;

  // exp(-2^(b-8)) in Q0.16
  function automatic logic [15:0] exp_step(input logic [3:0] b);
    logic [15:0] r;
    begin
      unique case (b)
        4'd0:    r = 16'd65280;
        4'd1:    r = 16'd65026;
        4'd2:    r = 16'd64520;
        4'd3:    r = 16'd63520;
        4'd4:    r = 16'd61565;
        4'd5:    r = 16'd57835;
        4'd6:    r = 16'd51039;
        4'd7:    r = 16'd39750;
        4'd8:    r = 16'd24109;
        4'd9:    r = 16'd8869;
        4'd10:   r = 16'd1200;
        4'd11:   r = 16'd22;
        default: r = 16'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: src/smd_exp.sv
// iterative exp(-k/256) unit, one bit of k per cycle
module smd_exp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [16:0] k_i,
  output logic        done_o,
  output logic [16:0] e_o
);
  import smd_pkg::*;

  logic        busy_q, busy_d;
  logic [3:0]  b_q, b_d;
  logic [11:0] k_q, k_d;
  logic [16:0] e_q, e_d;
  logic        done_q, done_d;
  logic [33:0] prod;

  assign prod = 34'(e_q) * 34'(exp_step(b_q)) + 34'd32768;

  always_comb begin
    busy_d = busy_q;
    b_d    = b_q;
    k_d    = k_q;
    e_d    = e_q;
    done_d = 1'b0;
    if (go_i) begin
      k_d = k_i[11:0];
      b_d = '0;
      if (k_i >= 17'd4096) begin
        e_d = '0;
        done_d = 1'b1;
      end else begin
        e_d = 17'd65536;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (k_q[b_q]) e_d = prod[32:16];
      b_d = b_q + 4'd1;
      if (b_q == 4'd11) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d;
    k_q <= k_d;
    e_q <= e_d;
  end

  assign done_o = done_q;
  assign e_o    = e_q;
endmodule

// File: src/smd_div.sv
// restoring divider, one quotient bit per cycle, then saturation and derivative
module smd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [39:0] num_i,
  input  logic [22:0] den_i,
  output logic        done_o,
  output logic [15:0] p_o,
  output logic [14:0] d_o
);
  localparam int unsigned NumW = 40;

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [39:0] quo_q;
  logic [23:0] rem_q;
  logic [22:0] den_q;
  logic [24:0] trial;
  logic [23:0] shifted;
  logic        mul_q, done_q;
  logic [15:0] p_q;
  logic [32:0] dprod;
  logic [14:0] d_q;

  assign shifted = {rem_q[22:0], quo_q[NumW-1]};
  assign trial   = {1'b0, shifted} - {2'b0, den_q};
  assign dprod   = 33'(p_q) * (33'd65536 - 33'(p_q)) + 33'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mul_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= mul_q;
      mul_q  <= 1'b0;
      if (go_i) busy_q <= 1'b1;
      else if (busy_q && cnt_q == 6'(NumW - 1)) begin
        busy_q <= 1'b0;
        mul_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
      cnt_q <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (!trial[24]) begin
        rem_q <= trial[23:0];
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
    if (mul_q) d_q <= dprod[30:16];
    else if (busy_q && cnt_q == 6'(NumW - 1)) begin
      // saturate quotient to 16 bits; zero sum gives zero
      if (den_q == '0) p_q <= '0;
      else if (quo_q[NumW-2:15] != '0) p_q <= 16'hFFFF;
      else p_q <= {quo_q[14:0], ~trial[24]};
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;
  assign d_o    = d_q;
endmodule

// File: src/softmax_with_derivative.sv
// softmax over a stored vector with the diagonal derivative
// load: takes a beat whenever start is high and the block is idle, tracking the maximum as elements are written
// exp pass: per element, S_ERD reads the score, S_EGO starts the bit-serial exp unit, S_EWT waits and sums
// divide pass: per element, S_DRD reads the exponential, S_DGO starts the 40-step divider, S_DWT waits
// results come one per strobe and cannot be stalled
// asynchronous active-low reset empties the vector; the stores need no clearing
module softmax_with_derivative #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  smd_pkg::smd_in_t    in_i,
  output logic                strobe,
  output smd_pkg::smd_out_t   out_o
);
  import smd_pkg::*;

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  localparam logic [2:0] S_LOAD = 3'd0, S_ERD = 3'd1, S_EGO = 3'd2, S_EWT = 3'd3,
                         S_DRD = 3'd4, S_DGO = 3'd5, S_DWT = 3'd6;

  logic [15:0] score_mem [MAX_LEN];
  logic [16:0] exp_mem   [MAX_LEN];
  logic [15:0] score_rd_q;
  logic [16:0] exp_rd_q;

  logic [2:0]  st_q;
  logic [CW-1:0] cnt_q, idx_q;
  logic signed [15:0] max_q;
  logic [22:0] sum_q;
  logic        strobe_q;
  smd_out_t    out_q;

  logic        acc;
  logic        exp_go, exp_done, div_go, div_done;
  logic [16:0] exp_e, kval;
  logic [15:0] p_w;
  logic [14:0] d_w;

  assign busy = (st_q != S_LOAD);
  assign acc  = start && !busy;
  assign kval = 17'($signed({max_q[15], max_q}) - $signed({score_rd_q[15], score_rd_q}));
  assign exp_go = (st_q == S_EGO);
  assign div_go = (st_q == S_DGO);

  always_ff @(posedge clk_i) begin
    if (acc && cnt_q < CW'(MAX_LEN)) score_mem[cnt_q[AW-1:0]] <= in_i.score;
    score_rd_q <= score_mem[idx_q[AW-1:0]];
    if (st_q == S_EWT && exp_done) exp_mem[idx_q[AW-1:0]] <= exp_e;
    exp_rd_q <= exp_mem[idx_q[AW-1:0]];
  end

  smd_exp u_exp (
    .clk_i, .rst_ni, .go_i(exp_go), .k_i(kval), .done_o(exp_done), .e_o(exp_e)
  );

  smd_div u_div (
    .clk_i, .rst_ni, .go_i(div_go), .num_i({7'd0, exp_rd_q, 16'd0} + 40'(sum_q[22:1])),
    .den_i(sum_q), .done_o(div_done), .p_o(p_w), .d_o(d_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_LOAD;
      cnt_q    <= '0;
      idx_q    <= '0;
      max_q    <= 16'sh8000;
      sum_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      unique case (st_q)
        S_LOAD: begin
          if (acc) begin
            if (cnt_q < CW'(MAX_LEN)) begin
              cnt_q <= cnt_q + 1'b1;
              if (in_i.score > max_q) max_q <= in_i.score;
            end
            if (in_i.last_element) begin
              idx_q <= '0;
              sum_q <= '0;
              st_q  <= S_ERD;
            end
          end
        end
        S_ERD: st_q <= S_EGO;
        S_EGO: st_q <= S_EWT;
        S_EWT: begin
          if (exp_done) begin
            sum_q <= sum_q + 23'(exp_e);
            if (idx_q + 1'b1 == cnt_q) begin
              idx_q <= '0;
              st_q  <= S_DRD;
            end else begin
              idx_q <= idx_q + 1'b1;
              st_q  <= S_ERD;
            end
          end
        end
        S_DRD: st_q <= S_DGO;
        S_DGO: st_q <= S_DWT;
        S_DWT: begin
          if (div_done) begin
            strobe_q <= 1'b1;
            out_q.probability <= p_w;
            out_q.derivative  <= d_w;
            out_q.last_result <= (idx_q + 1'b1 == cnt_q);
            if (idx_q + 1'b1 == cnt_q) begin
              cnt_q <= '0;
              max_q <= 16'sh8000;
              st_q  <= S_LOAD;
            end else begin
              idx_q <= idx_q + 1'b1;
              st_q  <= S_DRD;
            end
          end
        end
        default: st_q <= S_LOAD;
      endcase
    end
  end

  assign strobe = strobe_q;
  assign out_o  = out_q;

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(MAX_LEN))
    else $error("count overflow");
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && !out_q.last_result |-> busy)
    else $error("strobe outside emit");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && out_q.last_result |-> !busy)
    else $error("not idle after last");
  a_deriv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> out_q.derivative <= 15'd16384)
    else $error("derivative range");
`endif
endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the softmax block with derivative
module testbench;
  import smd_pkg::*;

  localparam int VEC_MAX = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  smd_in_t in_i = '0;
  logic strobe;
  smd_out_t out_o;

  softmax_with_derivative #(.MAX_LEN(VEC_MAX)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .strobe(strobe), .out_o(out_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  localparam logic [15:0] EXP_STEP [12] = '{
    16'd65280, 16'd65026, 16'd64520, 16'd63520, 16'd61565, 16'd57835,
    16'd51039, 16'd39750, 16'd24109, 16'd8869, 16'd1200, 16'd22
  };

  // predictor state
  logic signed [15:0] vec_scores [VEC_MAX];
  int unsigned vec_len = 0;
  logic signed [15:0] vec_max = -16'sd32768;

  smd_in_t pending_beats [$];
  smd_out_t expected_probs [$];
  int unsigned errors = 0;
  int idle_pct = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [16:0] exp_of_gap(int unsigned k);
    longint unsigned e;
    e = 65536;
    if (k >= 4096) return 17'd0;
    for (int b = 0; b < 12; b++)
      if (k[b]) e = (e * EXP_STEP[b] + 32768) >> 16;
    return e[16:0];
  endfunction

  task automatic predict_softmax(smd_in_t beat);
    logic [16:0] exps [VEC_MAX];
    longint unsigned total;
    longint unsigned p;
    longint unsigned d;
    smd_out_t r;
    total = 0;
    if (vec_len < VEC_MAX) begin
      vec_scores[vec_len] = beat.score;
      if (beat.score > vec_max) vec_max = beat.score;
      vec_len++;
    end
    if (!beat.last_element) return;
    for (int i = 0; i < vec_len; i++) begin
      exps[i] = exp_of_gap(int'(vec_max) - int'(vec_scores[i]));
      total = (total + exps[i]) & 23'h7FFFFF;
    end
    for (int i = 0; i < vec_len; i++) begin
      p = 0;
      d = 0;
      if (total != 0) begin
        p = ((longint'(exps[i]) << 16) + (total >> 1)) / total;
        if (p > 65535) p = 65535;
        d = (p * (65536 - p) + 32768) >> 16;
      end
      r.probability = p[15:0];
      r.derivative = d[14:0];
      r.last_result = (i + 1 == vec_len);
      expected_probs.push_back(r);
    end
    vec_len = 0;
    vec_max = -16'sd32768;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) predict_softmax(in_i);
      if (start && busy) begin
        // hold the beat
      end else if (pending_beats.size() != 0 && !hold_off &&
                   $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_i <= pending_beats.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    smd_out_t exp_r;
    if (rst_ni && strobe) begin
      if (expected_probs.size() == 0) begin
        $error("unexpected result %h", out_o);
        errors++;
      end else begin
        exp_r = expected_probs.pop_front();
        if (out_o.probability !== exp_r.probability) begin
          $error("probability exp %0d got %0d", exp_r.probability, out_o.probability);
          errors++;
        end
        if (out_o.derivative !== exp_r.derivative) begin
          $error("derivative exp %0d got %0d", exp_r.derivative, out_o.derivative);
          errors++;
        end
        if (out_o.last_result !== exp_r.last_result) begin
          $error("last_result exp %0d got %0d", exp_r.last_result, out_o.last_result);
          errors++;
        end
      end
    end
  end

  task automatic add_vector(int unsigned len, int mode);
    smd_in_t b;
    logic signed [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: b.score = 16'($urandom);
        1: b.score = base + $signed(16'($urandom_range(2047)) - 16'sd1024);
        default: b.score = base + $signed(16'($urandom_range(7)));
      endcase
      b.last_element = (i == len - 1);
      pending_beats.push_back(b);
    end
  endtask

  task automatic drain;
    while (pending_beats.size() != 0 || start) @(posedge clk_i);
    while (expected_probs.size() != 0 || busy) @(posedge clk_i);
  endtask

  initial begin
    smd_in_t b;
    int total_items;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: single elements at extremes, wide-spread pair, equal pair, three-element mix, overlong
    b = '{score: 16'sh7FFF, last_element: 1'b1}; pending_beats.push_back(b);
    b = '{score: -16'sd32768, last_element: 1'b1}; pending_beats.push_back(b);
    b = '{score: -16'sd32768, last_element: 1'b0}; pending_beats.push_back(b);
    b = '{score: 16'sh7FFF, last_element: 1'b1}; pending_beats.push_back(b);
    b = '{score: 16'sd0, last_element: 1'b0}; pending_beats.push_back(b);
    b = '{score: 16'sd0, last_element: 1'b1}; pending_beats.push_back(b);
    b = '{score: 16'sd256, last_element: 1'b0}; pending_beats.push_back(b);
    b = '{score: 16'sd0, last_element: 1'b0}; pending_beats.push_back(b);
    b = '{score: -16'sd4095, last_element: 1'b1}; pending_beats.push_back(b);
    drain();
    // overlong vector: 66 beats, extra ones dropped even if larger
    for (int i = 0; i < 66; i++) begin
      b.score = (i < 64) ? 16'($signed(i * 16)) : 16'sh7FFF;
      b.last_element = (i == 65);
      pending_beats.push_back(b);
    end
    drain();
    total_items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 45;
        2: idle_pct = 0;
        default: idle_pct = 12;
      endcase
      while (total_items < (ph + 1) * 90) begin
        int unsigned len;
        len = ($urandom_range(19) == 0) ? $urandom_range(64, 66) : $urandom_range(1, 8);
        add_vector(len, $urandom_range(2));
        total_items += len;
      end
      // send this phase's beats before the idle rate changes
      while (pending_beats.size() != 0 || start) @(posedge clk_i);
      if (ph == 1) begin
        hold_off = 1'b1;
        while (expected_probs.size() != 0 || busy) @(posedge clk_i);
        hold_off = 1'b0;
      end
    end
    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_probs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
